### hdl/bdq_pkg.sv
// shared types and codes for the bounded double-ended queue
`default_nettype none

package bdq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  localparam int WordWidth = 32;

endpackage

`default_nettype wire

### hdl/bdq_ram.sv
// slot memory: one write port, one registered read port
`default_nettype none

module bdq_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [AW-1:0]                          wr_addr,
  input  wire logic signed [bdq_pkg::WordWidth-1:0]   wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [AW-1:0]                          rd_addr,
  output logic signed [bdq_pkg::WordWidth-1:0]        rd_data
);

  logic signed [bdq_pkg::WordWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/bounded_double_ended_queue_top.sv
// bounded double-ended queue: ring front index and count around a slot memory
// timing: a push or a failed pop is registered straight into the result register; a successful
// pop passes through the slot memory's registered read port first, then the result register
// throughput: one push per cycle unless the output stalls; requests wait while a pop reads
// reset: front index and count cleared; slot memory is not cleared
`default_nettype none

module bounded_double_ended_queue_top #(
  parameter int CAPACITY = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output logic                                              in_stall,
  input  wire logic [1:0]                                   op,
  input  wire logic signed [bdq_pkg::WordWidth-1:0]         push_value,
  output logic                                              out_valid,
  input  wire logic                                         out_stall,
  output logic [1:0]                                        status,
  output logic signed [bdq_pkg::WordWidth-1:0]              popped_value,
  output logic [$clog2(CAPACITY+1)-1:0]                     fill_count
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0] head;
  logic [PW-1:0] head_next;
  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;
  logic          pending;
  logic          accept;
  logic          full;
  logic          empty;
  logic [SW-1:0] sum_back;
  logic [SW-1:0] sum_last;
  logic [SW-1:0] wrap_back;
  logic [SW-1:0] wrap_last;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] head_inc;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic signed [bdq_pkg::WordWidth-1:0] rd_data;
  bdq_pkg::status_t status_next;

  assign in_stall = pending | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign full     = (occ == CW'(CAPACITY));
  assign empty    = (occ == '0);

  assign sum_back  = SW'(head) + SW'(occ);
  assign sum_last  = sum_back - SW'(1);
  assign wrap_back = (sum_back >= SW'(CAPACITY)) ? sum_back - SW'(CAPACITY) : sum_back;
  assign wrap_last = (sum_last >= SW'(CAPACITY)) ? sum_last - SW'(CAPACITY) : sum_last;
  assign head_dec  = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);
  assign head_inc  = (head == PW'(CAPACITY - 1)) ? '0 : head + PW'(1);

  always_comb begin
    head_next   = head;
    occ_next    = occ;
    status_next = bdq_pkg::STATUS_OK;
    wr_en       = 1'b0;
    wr_addr     = head;
    rd_en       = 1'b0;
    rd_addr     = head;
    unique case (bdq_pkg::op_t'(op))
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = bdq_pkg::STATUS_OVERFLOW;
        end else begin
          head_next = head_dec;
          occ_next  = occ + CW'(1);
          wr_en     = accept;
          wr_addr   = head_dec;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = bdq_pkg::STATUS_OVERFLOW;
        end else begin
          occ_next = occ + CW'(1);
          wr_en    = accept;
          wr_addr  = wrap_back[PW-1:0];
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = bdq_pkg::STATUS_UNDERFLOW;
        end else begin
          head_next = head_inc;
          occ_next  = occ - CW'(1);
          rd_en     = accept;
          rd_addr   = head;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = bdq_pkg::STATUS_UNDERFLOW;
        end else begin
          occ_next = occ - CW'(1);
          rd_en    = accept;
          rd_addr  = wrap_last[PW-1:0];
        end
      end
      default: begin
        status_next = bdq_pkg::STATUS_OK;
      end
    endcase
  end

  bdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pending) begin
        pending   <= 1'b0;
        out_valid <= 1'b1;
      end else if (accept && !rd_en) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        head <= head_next;
        occ  <= occ_next;
        if (rd_en) begin
          pending <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pending) begin
      popped_value <= rd_data;
    end
    if (accept) begin
      status     <= status_next;
      fill_count <= occ_next;
      if (!rd_en) begin
        popped_value <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// testbench for the bounded double-ended queue: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH = 8;
  localparam int INDEX_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT = 10;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    bdq_pkg::status_t                      st;
    logic signed [bdq_pkg::WordWidth-1:0]  word;
    logic [FILL_W-1:0]                     fill;
  } outcome_t;

  logic                                  clk = 1'b0;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_stall;
  logic [1:0]                            op;
  logic signed [bdq_pkg::WordWidth-1:0]  push_value;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [1:0]                            status;
  logic signed [bdq_pkg::WordWidth-1:0]  popped_value;
  logic [FILL_W-1:0]                     fill_count;

  // predictor state
  logic signed [bdq_pkg::WordWidth-1:0]  ring_words [DEPTH];
  logic [INDEX_W-1:0]                    front_pos;
  logic [FILL_W-1:0]                     word_count;

  outcome_t pending_outcomes[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  bit       idle_on = 1'b1;

  bounded_double_ended_queue_top #(
    .CAPACITY (DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .fill_count   (fill_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void predict_outcome(bdq_pkg::op_t kind,
                                          logic signed [bdq_pkg::WordWidth-1:0] word);
    outcome_t res;
    res.st = bdq_pkg::STATUS_OK;
    res.word = '0;
    case (kind)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (word_count == DEPTH) begin
          res.st = bdq_pkg::STATUS_OVERFLOW;
        end else begin
          front_pos = INDEX_W'((int'(front_pos) + DEPTH - 1) % DEPTH);
          ring_words[front_pos] = word;
          word_count++;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (word_count == DEPTH) begin
          res.st = bdq_pkg::STATUS_OVERFLOW;
        end else begin
          ring_words[(int'(front_pos) + int'(word_count)) % DEPTH] = word;
          word_count++;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (word_count == 0) begin
          res.st = bdq_pkg::STATUS_UNDERFLOW;
        end else begin
          res.word = ring_words[front_pos];
          front_pos = INDEX_W'((int'(front_pos) + 1) % DEPTH);
          word_count--;
        end
      end
      default: begin
        if (word_count == 0) begin
          res.st = bdq_pkg::STATUS_UNDERFLOW;
        end else begin
          res.word = ring_words[(int'(front_pos) + int'(word_count) - 1) % DEPTH];
          word_count--;
        end
      end
    endcase
    res.fill = word_count;
    pending_outcomes.push_back(res);
  endfunction

  function automatic logic signed [bdq_pkg::WordWidth-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic bdq_pkg::op_t pick_op(int push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(bdq_pkg::op_t kind, logic signed [bdq_pkg::WordWidth-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    push_value <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_outcome(kind, word);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_pops();
    send_request(bdq_pkg::OP_POP_FRONT, 32'sh7fff_ffff);
    send_request(bdq_pkg::OP_POP_BACK, 32'sh8000_0000);
  endtask

  task automatic test_fill_to_overflow();
    send_request(bdq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
    send_request(bdq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    send_request(bdq_pkg::OP_PUSH_BACK, 32'sh0000_0000);
    send_request(bdq_pkg::OP_PUSH_BACK, -32'sd1);
    // front pushes wrap the head below slot zero
    send_request(bdq_pkg::OP_PUSH_FRONT, 32'shaaaa_aaaa);
    send_request(bdq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    send_request(bdq_pkg::OP_PUSH_FRONT, 32'sd1);
    send_request(bdq_pkg::OP_PUSH_FRONT, -32'sd2);
    send_request(bdq_pkg::OP_PUSH_FRONT, 32'sh1234_5678);
    send_request(bdq_pkg::OP_PUSH_BACK, 32'sh1357_9bdf);
  endtask

  task automatic test_drain_both_ends();
    repeat (4) begin
      send_request(bdq_pkg::OP_POP_FRONT, $urandom);
      send_request(bdq_pkg::OP_POP_BACK, $urandom);
    end
    send_request(bdq_pkg::OP_POP_BACK, $urandom);
    send_request(bdq_pkg::OP_POP_FRONT, $urandom);
  endtask

  task automatic test_random_mix(int segments);
    int seg;
    int push_pct;
    for (seg = 0; seg < segments; seg++) begin
      idle_on = (seg % 3 != 2);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      repeat (25) send_request(pick_op(push_pct), pick_word());
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (50) send_request(pick_op($urandom_range(30, 70)), pick_word());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = bdq_pkg::OP_PUSH_FRONT;
    push_value = '0;
    front_pos = '0;
    word_count = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_pops();
    test_fill_to_overflow();
    wait_for_results();
    test_drain_both_ends();
    wait_for_results();
    test_random_mix(18);
    wait_for_results();
    test_steady_stream();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    end
    if (mismatch_count == 0) begin
      $display("bounded_double_ended_queue_top verification clean");
    end else begin
      $display("bounded_double_ended_queue_top verification failed");
    end
    $finish;
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d value %0d fill %0d",
                                status, popped_value, fill_count));
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.st || popped_value !== want.word || fill_count !== want.fill) begin
          note_mismatch($sformatf(
            "mismatch: expected status %0d value %0d fill %0d, got status %0d value %0d fill %0d",
            want.st, want.word, want.fill, status, popped_value, fill_count));
        end
      end
    end
  end

  // no progress on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bounded_double_ended_queue_top verification failed");
        $finish;
      end
    end
  end

endmodule

### sim.f
hdl/bdq_pkg.sv
hdl/bdq_ram.sv
hdl/bounded_double_ended_queue_top.sv
verif/tb_top.sv
